@@ design/ndps_pkg.sv @@
// ----------------------------------------------------------------------------
// ndps_pkg: shared types and constants of the neuron unit
// Fixed point formats, sigmoid table and the function that builds it.
// ----------------------------------------------------------------------------
package ndps_pkg;

   localparam int SIG_ENTRIES = 256;
   localparam int SIG_IDX_W   = 8;
   localparam int SEG_SHIFT   = 20;
   localparam int LADDER_MAX  = 128;
   localparam int ACC_W       = 40;
   localparam int SUM_W       = 32;
   localparam int ACT_W       = 16;
   localparam int MUL_A_W     = 17;
   localparam int MUL_B_W     = 21;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   localparam logic [63:0] ONE_Q32  = 64'd4294967296;
   localparam logic [63:0] ROOT_Q32 = 64'd4571968696;

   typedef logic [ACT_W-1:0] sig_table_type [SIG_ENTRIES];

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_root(input logic [63:0] p);
      logic [63:0] frac;
      logic [63:0] hi;
      logic [63:0] lo;
      frac = ROOT_Q32 - ONE_Q32;
      hi   = p >> 32;
      lo   = p & 64'hFFFF_FFFF;
      return p + hi * frac + ((lo * frac + 64'h8000_0000) >> 32);
   endfunction

   function automatic sig_table_type build_sig_table();
      logic [63:0] ladder [LADDER_MAX+1];
      logic [63:0] b;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      sig_table_type t;
      int m;
      int a;
      ladder[0] = ONE_Q32;
      for (int n = 1; n <= LADDER_MAX; n++) begin
         ladder[n] = mul_root(ladder[n-1]);
      end
      for (int k = 0; k < SIG_ENTRIES; k++) begin
         m = k - SIG_ENTRIES / 2;
         a = (m < 0) ? -m : m;
         if (a > LADDER_MAX) begin
            a = LADDER_MAX;
         end
         b   = ladder[a];
         den = b + ONE_Q32;
         num = (m >= 0) ? 64'd65535 * b : 64'd65535 * ONE_Q32;
         q   = udiv64(2 * num + den, 2 * den);
         t[k] = q[ACT_W-1:0];
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

@@ design/neuron_dot_product_sigmoid_unit.sv @@
// ----------------------------------------------------------------------------
// neuron_dot_product_sigmoid_unit: one neuron, weighted sum and sigmoid
// Accumulates Q4.12 sample and weight products into a saturating Q16.24 sum
// and on the last item emits the Q8.24 sum with its interpolated logistic.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample and weight pair per item; req_last closes an
//   evaluation. rsp_* carries one item per evaluation: the clipped sum and
//   its activation. Both channels use valid and stall.
// Sequencing:
//   One multiplier is shared by the product and by the table interpolation,
//   under a small sequencer. A non-last item is accepted, multiplied and
//   accumulated; a last item then clips the sum and reads the table, runs the
//   interpolation multiply, and writes the output register once it is free.
//   req_stall is high while an item is at work.
// Reset:
//   Synchronous reset clears the sum, the item count and the output valid.
// Stall:
//   A result waits in the output register while rsp_stall is high; the
//   block takes new items meanwhile and holds a further result in its last
//   step until the register frees.
// ----------------------------------------------------------------------------
module neuron_dot_product_sigmoid_unit #(
   parameter int MAX_INPUTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [15:0]                req_sample_value,
   input  logic signed [15:0]                req_weight_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ndps_pkg::ACT_W-1:0]        rsp_activation,
   output logic signed [ndps_pkg::SUM_W-1:0] rsp_weighted_sum
);

   localparam int CNT_W = $clog2(MAX_INPUTS + 1);
   localparam int ACC_W = ndps_pkg::ACC_W;
   localparam int SUM_W = ndps_pkg::SUM_W;
   localparam int ACT_W = ndps_pkg::ACT_W;
   localparam int IDX_W = SUM_W - ndps_pkg::SEG_SHIFT;
   localparam int FRC_W = ndps_pkg::SEG_SHIFT;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_ACT1 = 3'd3;
   localparam logic [2:0] ST_ACT2 = 3'd4;
   localparam logic [2:0] ST_ACT3 = 3'd5;

   localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};

   logic [2:0]                          state_ff, state_in;
   logic signed [15:0]                  sample_ff, weight_ff;
   logic                                last_ff;
   logic signed [ACC_W-1:0]             acc_ff, acc_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic signed [ndps_pkg::MUL_P_W-1:0] mul_ff;
   logic signed [ndps_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ndps_pkg::MUL_B_W-1:0] mul_b;
   logic signed [SUM_W-1:0]             ws_ff, ws_in;
   logic [ACT_W-1:0]                    base_ff, base_in;
   logic [ACT_W-1:0]                    diff_ff, diff_in;
   logic [FRC_W-1:0]                    frac_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]                    rsp_act_ff;
   logic signed [SUM_W-1:0]             rsp_sum_ff;

   logic                    accept;
   logic                    out_free;
   logic signed [ACC_W:0]   acc_sum;
   logic signed [SUM_W:0]   u_val;
   logic [IDX_W-1:0]        idx;
   logic [ndps_pkg::SIG_IDX_W-1:0] idx_lo, idx_hi;
   logic [ACT_W-1:0]        t_lo, t_hi;
   logic [35:0]             interp;
   logic [ACT_W-1:0]        act_in;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (state_ff == ST_ACT2) begin
         mul_a = {1'b0, diff_ff};
         mul_b = {1'b0, frac_ff};
      end else begin
         mul_a = {sample_ff[15], sample_ff};
         mul_b = {{(ndps_pkg::MUL_B_W-16){weight_ff[15]}}, weight_ff};
      end
   end

   always_comb begin
      acc_sum = {acc_ff[ACC_W-1], acc_ff} + {{(ACC_W-31){mul_ff[31]}}, mul_ff[31:0]};
   end

   always_comb begin
      if (acc_ff[ACC_W-1:SUM_W-1] == '0 || acc_ff[ACC_W-1:SUM_W-1] == '1) begin
         ws_in = acc_ff[SUM_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         ws_in = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         ws_in = {1'b0, {(SUM_W-1){1'b1}}};
      end
      u_val  = {ws_in[SUM_W-1], ws_in} + (SUM_W+1)'(33'sd134217728);
      idx    = u_val[SUM_W-1:FRC_W];
      idx_lo = idx[ndps_pkg::SIG_IDX_W-1:0];
      idx_hi = idx_lo + 1'b1;
      t_lo   = ndps_pkg::SIG_TABLE[idx_lo];
      t_hi   = ndps_pkg::SIG_TABLE[idx_hi];
      priority if (u_val[SUM_W]) begin
         base_in = ndps_pkg::SIG_TABLE[0];
         diff_in = '0;
      end else if (idx >= IDX_W'(ndps_pkg::SIG_ENTRIES - 1)) begin
         base_in = ndps_pkg::SIG_TABLE[ndps_pkg::SIG_ENTRIES-1];
         diff_in = '0;
      end else if (t_hi < t_lo) begin
         base_in = t_lo;
         diff_in = '0;
      end else begin
         base_in = t_lo;
         diff_in = t_hi - t_lo;
      end
   end

   always_comb begin
      interp = mul_ff[35:0] + 36'(1 << (FRC_W - 1));
      act_in = base_ff + interp[FRC_W +: ACT_W];
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (count_ff < CNT_W'(MAX_INPUTS)) begin
               count_in = count_ff + 1'b1;
               if (acc_sum > ACC_MAX) begin
                  acc_in = ACC_MAX[ACC_W-1:0];
               end else if (acc_sum < ACC_MIN) begin
                  acc_in = ACC_MIN[ACC_W-1:0];
               end else begin
                  acc_in = acc_sum[ACC_W-1:0];
               end
            end
            state_in = last_ff ? ST_ACT1 : ST_IDLE;
         end
         ST_ACT1: begin
            acc_in   = '0;
            count_in = '0;
            state_in = ST_ACT2;
         end
         ST_ACT2: begin
            state_in = ST_ACT3;
         end
         ST_ACT3: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample_value;
         weight_ff <= req_weight_value;
         last_ff   <= req_last;
      end
      if (state_ff == ST_MUL || state_ff == ST_ACT2) begin
         mul_ff <= mul_a * mul_b;
      end
      if (state_ff == ST_ACT1) begin
         ws_ff   <= ws_in;
         base_ff <= base_in;
         diff_ff <= diff_in;
         frac_ff <= u_val[FRC_W-1:0];
      end
      if (state_ff == ST_ACT3 && out_free) begin
         rsp_act_ff <= act_in;
         rsp_sum_ff <= ws_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_activation   = rsp_act_ff;
   assign rsp_weighted_sum = rsp_sum_ff;

endmodule

@@ design/ndps_checker.sv @@
// ----------------------------------------------------------------------------
// ndps_checker: port level checks of the neuron unit
// Watches the handshakes and the result timing of the top level.
// ----------------------------------------------------------------------------
module ndps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_activation,
   input logic [31:0] rsp_weighted_sum
);

   logic req_acc;

   assign req_acc = req_valid && !req_stall;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_activation) && $stable(rsp_weighted_sum))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("item taken while previous item at work");

   assert property (@(posedge clock) disable iff (reset)
      req_acc && req_last && !rsp_valid |-> ##6 rsp_valid)
      else $error("missing result for last item");

   assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_last && !rsp_valid |=> !rsp_valid)
      else $error("result without last item");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind neuron_dot_product_sigmoid_unit ndps_checker u_ndps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_activation   (rsp_activation),
   .rsp_weighted_sum (rsp_weighted_sum)
);

@@ bench/neuron_result_monitor.sv @@
// ----------------------------------------------------------------------------
// neuron_result_monitor: predicts and checks the neuron unit's results
// Watches both channels. It keeps its own saturating sum and a logistic
// table built in Q32, queues one sum and activation per evaluation, and
// compares every accepted result field by field.
// ----------------------------------------------------------------------------
module neuron_result_monitor #(
   parameter int INPUT_LIMIT = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [15:0]                req_sample_value,
   input  logic signed [15:0]                req_weight_value,
   input  logic                              req_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [ndps_pkg::ACT_W-1:0]        rsp_activation,
   input  logic signed [ndps_pkg::SUM_W-1:0] rsp_weighted_sum,
   output int                                fail_count,
   output int                                pending_results
);

   localparam int          LUT_ENTRIES = 256;
   localparam int          LADDER_TOP  = 128;
   localparam int          SEG_BITS    = 20;
   localparam logic [63:0] UNITY_Q32   = 64'd4294967296;
   localparam logic [63:0] ROOT_FRAC   = 64'd277001400;
   localparam longint      ACC_HI      = 64'sd549755813887;
   localparam longint      ACC_LO      = -ACC_HI - 1;
   localparam longint      SUM_HI      = 64'sd2147483647;
   localparam longint      SUM_LO      = -SUM_HI - 1;
   localparam int          MAX_PRINTS  = 50;

   typedef struct packed {
      logic [ndps_pkg::ACT_W-1:0]        activation;
      logic signed [ndps_pkg::SUM_W-1:0] weighted_sum;
   } neuron_out_type;

   logic [15:0]    logistic_lut [LUT_ENTRIES];
   neuron_out_type evaluation_q [$];
   longint         running_sum;
   int             taken;

   function automatic void fill_logistic_lut();
      logic [63:0] ladder [LADDER_TOP+1];
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] num;
      logic [63:0] den;
      int          m;
      int          a;
      ladder[0] = UNITY_Q32;
      for (int n = 1; n <= LADDER_TOP; n++) begin
         hi = ladder[n-1] >> 32;
         lo = ladder[n-1] & 64'hFFFF_FFFF;
         ladder[n] = ladder[n-1] + hi * ROOT_FRAC + ((lo * ROOT_FRAC + 64'h8000_0000) >> 32);
      end
      for (int k = 0; k < LUT_ENTRIES; k++) begin
         m   = k - LUT_ENTRIES / 2;
         a   = (m < 0) ? -m : m;
         den = ladder[a] + UNITY_Q32;
         num = 64'd65535 * ((m >= 0) ? ladder[a] : UNITY_Q32);
         logistic_lut[k] = 16'((2 * num + den) / (2 * den));
      end
   endfunction

   function automatic logic [15:0] logistic_of(input longint ws);
      longint      u;
      longint      seg;
      longint      frac;
      longint      rise;
      logic [15:0] lo;
      logic [15:0] hi;
      u = ws + (longint'(8) <<< 24);
      if (u < 0) begin
         return logistic_lut[0];
      end
      seg = u >>> SEG_BITS;
      if (seg >= LUT_ENTRIES - 1) begin
         return logistic_lut[LUT_ENTRIES-1];
      end
      frac = u & ((longint'(1) <<< SEG_BITS) - 1);
      lo   = logistic_lut[seg];
      hi   = logistic_lut[seg+1];
      if (hi < lo) begin
         return lo;
      end
      rise = ((longint'(hi) - longint'(lo)) * frac + (longint'(1) <<< (SEG_BITS - 1))) >>> SEG_BITS;
      return lo + rise[15:0];
   endfunction

   task automatic absorb_pair(input logic signed [15:0] s, input logic signed [15:0] w,
                              input logic closing);
      longint         total;
      neuron_out_type r;
      if (taken < INPUT_LIMIT) begin
         total = running_sum + longint'(s) * longint'(w);
         if (total > ACC_HI) begin
            total = ACC_HI;
         end
         if (total < ACC_LO) begin
            total = ACC_LO;
         end
         running_sum = total;
         taken++;
      end
      if (closing) begin
         total = running_sum;
         if (total > SUM_HI) begin
            total = SUM_HI;
         end
         if (total < SUM_LO) begin
            total = SUM_LO;
         end
         r.weighted_sum = total[31:0];
         r.activation   = logistic_of(total);
         evaluation_q.push_back(r);
         running_sum = 0;
         taken       = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (fail_count < MAX_PRINTS) begin
         $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
      end
      fail_count++;
   endtask

   initial begin
      fill_logistic_lut();
   end

   always @(posedge clock) begin
      neuron_out_type want;
      if (reset) begin
         running_sum = 0;
         taken       = 0;
         fail_count  = 0;
         evaluation_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            absorb_pair(req_sample_value, req_weight_value, req_last);
         end
         if (rsp_valid && !rsp_stall) begin
            if (evaluation_q.size() == 0) begin
               report_mismatch("unexpected result, weighted_sum", rsp_weighted_sum, 0);
            end else begin
               want = evaluation_q.pop_front();
               if (rsp_activation !== want.activation) begin
                  report_mismatch("activation", rsp_activation, want.activation);
               end
               if (rsp_weighted_sum !== want.weighted_sum) begin
                  report_mismatch("weighted_sum", rsp_weighted_sum, want.weighted_sum);
               end
            end
         end
      end
      pending_results = evaluation_q.size();
   end

endmodule

@@ bench/neuron_dot_product_sigmoid_unit_tb.sv @@
// ----------------------------------------------------------------------------
// neuron_dot_product_sigmoid_unit_tb: stimulus and verdict for the neuron unit
// Sends directed corner evaluations, then random evaluations of mixed length
// and value spread, with random gaps on the request side and random stalls
// on the result side. A monitor beside the block checks every result.
// ----------------------------------------------------------------------------
module neuron_dot_product_sigmoid_unit_tb;

   localparam int NEURON_INPUTS = 64;
   localparam int ITEM_TARGET   = 1550;
   localparam int DRAIN_CYCLES  = 20;

   typedef enum int {
      VAL_FULL,
      VAL_WIDE,
      VAL_NARROW,
      VAL_CORNER
   } value_mode_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [15:0]                req_sample_value;
   logic signed [15:0]                req_weight_value;
   logic                              req_last;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [ndps_pkg::ACT_W-1:0]        rsp_activation;
   logic signed [ndps_pkg::SUM_W-1:0] rsp_weighted_sum;
   int                                fail_count;
   int                                pending_results;
   int                                items_sent;

   neuron_dot_product_sigmoid_unit #(
      .MAX_INPUTS (NEURON_INPUTS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_weight_value (req_weight_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_activation   (rsp_activation),
      .rsp_weighted_sum (rsp_weighted_sum)
   );

   neuron_result_monitor #(
      .INPUT_LIMIT (NEURON_INPUTS)
   ) u_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_weight_value (req_weight_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_activation   (rsp_activation),
      .rsp_weighted_sum (rsp_weighted_sum),
      .fail_count       (fail_count),
      .pending_results  (pending_results)
   );

   function automatic logic signed [15:0] pick_value(input value_mode_type mode);
      int unsigned span;
      case (mode)
         VAL_WIDE:   span = 8192;
         VAL_NARROW: span = 2048;
         VAL_CORNER: begin
            case ($urandom_range(0, 5))
               0:       return -16'sd32768;
               1:       return 16'sd32767;
               2:       return 16'sd0;
               3:       return 16'sd1;
               4:       return -16'sd1;
               default: return 16'sd4096;
            endcase
         end
         default:    return 16'($urandom);
      endcase
      return 16'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic int gap_length(input bit steady);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 70) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 25);
   endfunction

   // enter and leave at a falling edge; valid stays high after the item
   task automatic send_item(input logic signed [15:0] s, input logic signed [15:0] w,
                            input logic closing);
      req_valid        <= 1'b1;
      req_sample_value <= s;
      req_weight_value <= w;
      req_last         <= closing;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_valid        <= 1'b0;
         req_sample_value <= 16'($urandom);
         req_weight_value <= 16'($urandom);
         req_last         <= 1'($urandom);
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic send_evaluation(input int len, input value_mode_type mode, input bit steady);
      for (int i = 0; i < len; i++) begin
         pause(gap_length(steady));
         send_item(pick_value(mode), pick_value(mode), i == len - 1);
      end
   endtask

   task automatic wait_results_drained();
      while (pending_results != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned stall_pick;
      int          stall_len;
      logic        stall_level;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 20) begin
            stall_level = 1'b0;
            stall_len   = $urandom_range(20, 150);
         end else if (stall_pick < 65) begin
            stall_level = 1'b0;
            stall_len   = 1;
         end else if (stall_pick < 95) begin
            stall_level = 1'b1;
            stall_len   = $urandom_range(1, 3);
         end else begin
            stall_level = 1'b1;
            stall_len   = $urandom_range(10, 40);
         end
         rsp_stall <= stall_level;
         repeat (stall_len) @(negedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned len_pick;
      int          len;
      bit          paused_mid;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      req_weight_value = '0;
      req_last         = 1'b0;
      items_sent       = 0;
      paused_mid       = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_item(16'sd0, 16'sd0, 1'b1);
      send_item(16'sd32767, 16'sd32767, 1'b1);
      send_item(-16'sd32768, -16'sd32768, 1'b0);
      send_item(-16'sd32768, -16'sd32768, 1'b1);
      send_item(-16'sd32768, 16'sd32767, 1'b0);
      send_item(-16'sd32768, 16'sd32767, 1'b1);
      send_item(16'sd4096, 16'sd4096, 1'b0);
      send_item(-16'sd4096, 16'sd2048, 1'b1);
      send_item(-16'sd32768, 16'sd4096, 1'b1);
      send_item(16'sd32767, 16'sd4096, 1'b1);
      send_item(16'sd1, 16'sd1, 1'b1);
      send_item(-16'sd1, 16'sd1, 1'b1);
      send_item(16'sd16384, 16'sd30000, 1'b0);
      send_item(16'sd12345, -16'sd23456, 1'b0);
      send_item(-16'sd1, -16'sd1, 1'b1);
      send_item(16'sd32767, -16'sd32768, 1'b0);
      send_item(16'sd0, 16'sd0, 1'b1);
      send_item(16'sh5555, -16'sh5556, 1'b1);
      send_item(-16'sh5556, 16'sh5555, 1'b1);
      send_item(16'sd3000, -16'sd5000, 1'b1);
      pause(1);
      wait_results_drained();

      while (items_sent < ITEM_TARGET) begin
         len_pick = $urandom_range(0, 99);
         if (len_pick < 4) begin
            len = $urandom_range(60, 90);
         end else if (len_pick < 60) begin
            len = $urandom_range(1, 4);
         end else begin
            len = $urandom_range(5, 16);
         end
         send_evaluation(len, value_mode_type'($urandom_range(0, 3)),
                         $urandom_range(0, 9) < 3);
         if (!paused_mid && items_sent >= ITEM_TARGET / 2) begin
            paused_mid = 1'b1;
            pause(1);
            wait_results_drained();
         end
      end

      pause(1);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
